>>> hw/rtl/pur_pkg.sv
// Shared types and constants for the polyline uniform resampler.
package pur_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int PROD_W = 66;

  localparam logic [6:0] SAMPLES_MIN = 7'd2;
  localparam logic [6:0] SAMPLES_MAX = 7'd64;
  localparam logic [6:0] SAMPLES_RESET = 7'd16;

  localparam logic [31:0] TOL_Q16 = 32'd7;
  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;
  localparam logic [63:0] SQRT_BIT_INIT = 64'h4000_0000_0000_0000;
  localparam logic [40:0] QUOT_SAT = 41'h100_0000_0000;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQUARE,
    F_SQRT,
    F_WRITE,
    F_PUSH,
    F_DRAIN
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_TOT_RD,
    B_TOT,
    B_POS_MUL,
    B_POS_DIV,
    B_LO_RD,
    B_LO,
    B_SCAN_RD,
    B_SCAN,
    B_A_RD,
    B_A,
    B_B,
    B_PREP,
    B_MUL,
    B_IDIV,
    B_FIX
  } back_state_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        len;
  } vertex_rec_t;

  typedef struct packed {
    logic        en;
    vertex_rec_t rec;
  } mem_wr_t;

  typedef struct packed {
    logic [6:0] samples;
  } job_t;

endpackage

>>> hw/rtl/pur_ifs.sv
// Valid/ready channel interfaces for vertex and sample words.
interface pur_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               vertex_last;

  modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_last, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, vertex_last, output ready);
endinterface

interface pur_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic signed [31:0] sample_z;
  logic               sample_last;

  modport source (output valid, sample_x, sample_y, sample_z, sample_last, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, sample_last, output ready);
endinterface

>>> hw/rtl/pur_queue.sv
// Short job queue between the loader and the emitter.
module pur_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pur_pkg::job_t push_job,
  input  logic          pop,
  output pur_pkg::job_t head,
  output logic          full,
  output logic          empty
);

  localparam int PW = (pur_pkg::QUEUE_DEPTH > 1) ? $clog2(pur_pkg::QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(pur_pkg::QUEUE_DEPTH + 1);

  pur_pkg::job_t entries [pur_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill == FW'(pur_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(pur_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(pur_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

>>> hw/rtl/pur_front.sv
// Vertex loader: segment length by serial squaring and square root, store write.
module pur_front #(
  parameter int  MAX_POINTS = pur_pkg::MAX_POINTS_DEF,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  pur_vertex_if.sink       vertex,
  input  logic [6:0]       samples,
  input  logic             back_busy,
  input  logic             queue_full,
  input  logic             queue_empty,
  output logic             queue_push,
  output pur_pkg::job_t    queue_job,
  output pur_pkg::mem_wr_t mem_wr,
  output logic [AW-1:0]    mem_addr,
  output logic [CW-1:0]    path_len
);

  pur_pkg::front_state_t state, state_next;

  logic [CW-1:0]      count;
  logic signed [31:0] cur_x, cur_y, cur_z;
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic [31:0]        prev_len;
  logic               last_q;
  logic [1:0]         sq_idx;
  logic [63:0]        sum;
  logic               big;
  logic [63:0]        sq_n, sq_res, sq_bit;
  logic [4:0]         sq_cnt;
  logic [31:0]        seg;

  logic               accept;
  logic [32:0]        diff;
  logic [32:0]        mag;
  logic [63:0]        sq;
  logic [64:0]        sum_add;
  logic               big_now;
  logic [63:0]        sq_t;
  logic               sq_ge;
  logic [63:0]        n_next, res_next;
  logic [32:0]        len_sum;
  logic [31:0]        len_new;

  assign accept   = vertex.valid && vertex.ready;
  assign path_len = count;
  assign mem_addr = count[AW-1:0];
  assign queue_job.samples = samples;

  // Differences are taken one axis per cycle through a single multiplier.
  always_comb begin
    case (sq_idx)
      2'd0:    diff = {cur_x[31], cur_x} - {prev_x[31], prev_x};
      2'd1:    diff = {cur_y[31], cur_y} - {prev_y[31], prev_y};
      default: diff = {cur_z[31], cur_z} - {prev_z[31], prev_z};
    endcase
    mag     = diff[32] ? (33'd0 - diff) : diff;
    sq      = mag[31:0] * mag[31:0];
    sum_add = {1'b0, sum} + {1'b0, sq};
    big_now = big || mag[32] || sum_add[64];
  end

  always_comb begin
    sq_t     = sq_res + sq_bit;
    sq_ge    = (sq_n >= sq_t);
    n_next   = sq_ge ? (sq_n - sq_t) : sq_n;
    res_next = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
    len_sum  = {1'b0, prev_len} + {1'b0, seg};
    if (count == '0) begin
      len_new = '0;
    end else begin
      len_new = len_sum[32] ? pur_pkg::LEN_MAX : len_sum[31:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pur_pkg::F_IDLE: begin
        if (accept) begin
          if (count == CW'(MAX_POINTS)) begin
            state_next = vertex.vertex_last ? pur_pkg::F_PUSH : pur_pkg::F_IDLE;
          end else if (count == '0) begin
            state_next = pur_pkg::F_WRITE;
          end else begin
            state_next = pur_pkg::F_SQUARE;
          end
        end
      end
      pur_pkg::F_SQUARE: begin
        if (sq_idx == 2'd2) begin
          state_next = big_now ? pur_pkg::F_WRITE : pur_pkg::F_SQRT;
        end
      end
      pur_pkg::F_SQRT: begin
        if (sq_cnt == 5'd31) begin
          state_next = pur_pkg::F_WRITE;
        end
      end
      pur_pkg::F_WRITE: begin
        state_next = last_q ? pur_pkg::F_PUSH : pur_pkg::F_IDLE;
      end
      pur_pkg::F_PUSH: begin
        if (!queue_full) begin
          state_next = pur_pkg::F_DRAIN;
        end
      end
      pur_pkg::F_DRAIN: begin
        // hold the store until the emitter has finished with it
        if (queue_empty && !back_busy) begin
          state_next = pur_pkg::F_IDLE;
        end
      end
      default: state_next = pur_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    vertex.ready   = (state == pur_pkg::F_IDLE);
    queue_push     = (state == pur_pkg::F_PUSH) && !queue_full;
    mem_wr.en      = (state == pur_pkg::F_WRITE);
    mem_wr.rec.x   = cur_x;
    mem_wr.rec.y   = cur_y;
    mem_wr.rec.z   = cur_z;
    mem_wr.rec.len = len_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pur_pkg::F_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == pur_pkg::F_WRITE) begin
        count <= count + 1'b1;
      end else if (state == pur_pkg::F_DRAIN && state_next == pur_pkg::F_IDLE) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pur_pkg::F_IDLE: begin
        if (accept) begin
          cur_x  <= vertex.vertex_x;
          cur_y  <= vertex.vertex_y;
          cur_z  <= vertex.vertex_z;
          last_q <= vertex.vertex_last;
          sq_idx <= '0;
          sum    <= '0;
          big    <= 1'b0;
        end
      end
      pur_pkg::F_SQUARE: begin
        sum    <= sum_add[63:0];
        big    <= big_now;
        sq_idx <= sq_idx + 1'b1;
        seg    <= pur_pkg::LEN_MAX;
        sq_n   <= sum_add[63:0];
        sq_res <= '0;
        sq_bit <= pur_pkg::SQRT_BIT_INIT;
        sq_cnt <= '0;
      end
      pur_pkg::F_SQRT: begin
        sq_n   <= n_next;
        sq_res <= res_next;
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 1'b1;
        seg    <= res_next[31:0];
      end
      pur_pkg::F_WRITE: begin
        prev_x   <= cur_x;
        prev_y   <= cur_y;
        prev_z   <= cur_z;
        prev_len <= len_new;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/pur_back.sv
// Sample emitter: vertex store, segment scan, shared serial divider, interpolation.
module pur_back #(
  parameter int  MAX_POINTS = pur_pkg::MAX_POINTS_DEF,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  pur_pkg::mem_wr_t mem_wr,
  input  logic [AW-1:0]    mem_addr,
  input  logic [CW-1:0]    path_len,
  input  logic             queue_empty,
  input  pur_pkg::job_t    queue_head,
  output logic             queue_pop,
  output logic             busy,
  pur_sample_if.source     sample
);

  localparam int PW = pur_pkg::PROD_W;

  pur_pkg::back_state_t state, state_next;

  pur_pkg::vertex_rec_t mem [MAX_POINTS];
  pur_pkg::vertex_rec_t rd_q;
  pur_pkg::vertex_rec_t a_rec, b_rec;

  logic [AW-1:0]      ptr;
  logic [6:0]         m_eff;
  logic [6:0]         idx;
  logic [31:0]        total, pos, lo_len, hi_len;
  logic [1:0]         coord;
  logic [PW-1:0]      mul_acc, mul_a;
  logic [32:0]        mul_b;
  logic [6:0]         cnt;
  logic [PW-1:0]      div_num;
  logic [32:0]        div_rem;
  logic [31:0]        div_den;
  logic               neg;
  logic signed [31:0] res [3];
  logic               out_valid;
  logic signed [31:0] out_x, out_y, out_z;
  logic               out_last;

  logic [CW-1:0]      len_m1;
  logic               single;
  logic [6:0]         m_clamp;
  logic [32:0]        rem_sh, rem_new;
  logic               fits;
  logic [PW-1:0]      num_new;
  logic [PW-1:0]      acc_next;
  logic               lo_ok, hi_ok, scan_end;
  logic signed [31:0] a_c, b_c;
  logic [32:0]        diff, d_val, diff_mag, d_mag;
  logic [31:0]        seg;
  logic               trivial;
  logic [40:0]        q_sat;
  logic signed [41:0] r_wide;
  logic signed [31:0] r_clamp;
  logic               emit_go;

  assign len_m1   = path_len - CW'(1);
  assign single   = (path_len == CW'(1));
  assign busy     = (state != pur_pkg::B_IDLE);
  assign scan_end = (CW'(ptr) == len_m1);

  assign sample.valid       = out_valid;
  assign sample.sample_x    = out_x;
  assign sample.sample_y    = out_y;
  assign sample.sample_z    = out_z;
  assign sample.sample_last = out_last;

  always_comb begin
    if (queue_head.samples < pur_pkg::SAMPLES_MIN) begin
      m_clamp = pur_pkg::SAMPLES_MIN;
    end else if (queue_head.samples > pur_pkg::SAMPLES_MAX) begin
      m_clamp = pur_pkg::SAMPLES_MAX;
    end else begin
      m_clamp = queue_head.samples;
    end
  end

  // One restoring step; the quotient shifts in behind the dividend.
  always_comb begin
    rem_sh   = {div_rem[31:0], div_num[PW-1]};
    fits     = (rem_sh >= {1'b0, div_den});
    rem_new  = fits ? (rem_sh - {1'b0, div_den}) : rem_sh;
    num_new  = {div_num[PW-2:0], fits};
    acc_next = mul_b[0] ? (mul_acc + mul_a) : mul_acc;
  end

  always_comb begin
    lo_ok = ({2'b0, pos} + {2'b0, pur_pkg::TOL_Q16}) >= {2'b0, lo_len};
    hi_ok = {1'b0, pos} <= ({1'b0, rd_q.len} + {1'b0, pur_pkg::TOL_Q16});
  end

  always_comb begin
    case (coord)
      2'd0: begin
        a_c = a_rec.x;
        b_c = b_rec.x;
      end
      2'd1: begin
        a_c = a_rec.y;
        b_c = b_rec.y;
      end
      default: begin
        a_c = a_rec.z;
        b_c = b_rec.z;
      end
    endcase
    diff     = {b_c[31], b_c} - {a_c[31], a_c};
    d_val    = {1'b0, pos} - {1'b0, lo_len};
    diff_mag = diff[32] ? (33'd0 - diff) : diff;
    d_mag    = d_val[32] ? (33'd0 - d_val) : d_val;
    seg      = hi_len - lo_len;
    // a one-vertex path repeats its vertex on every axis
    trivial  = single || (diff == '0) || (d_val == '0) || (seg == '0);
  end

  always_comb begin
    q_sat   = (div_num > PW'(pur_pkg::QUOT_SAT)) ? pur_pkg::QUOT_SAT : div_num[40:0];
    r_wide  = neg ? ({{10{a_c[31]}}, a_c} - $signed({1'b0, q_sat}))
                  : ({{10{a_c[31]}}, a_c} + $signed({1'b0, q_sat}));
    if (r_wide > 42'sd2147483647) begin
      r_clamp = 32'sh7FFF_FFFF;
    end else if (r_wide < -42'sd2147483648) begin
      r_clamp = 32'sh8000_0000;
    end else begin
      r_clamp = r_wide[31:0];
    end
  end

  assign emit_go = !out_valid || sample.ready;

  always_comb begin
    state_next = state;
    case (state)
      pur_pkg::B_IDLE:    if (!queue_empty) state_next = pur_pkg::B_TOT_RD;
      pur_pkg::B_TOT_RD:  state_next = pur_pkg::B_TOT;
      pur_pkg::B_TOT:     state_next = pur_pkg::B_POS_MUL;
      pur_pkg::B_POS_MUL: state_next = single ? pur_pkg::B_A_RD : pur_pkg::B_POS_DIV;
      pur_pkg::B_POS_DIV: if (cnt == 7'(PW - 1)) state_next = pur_pkg::B_LO_RD;
      pur_pkg::B_LO_RD:   state_next = pur_pkg::B_LO;
      pur_pkg::B_LO:      state_next = pur_pkg::B_SCAN_RD;
      pur_pkg::B_SCAN_RD: state_next = pur_pkg::B_SCAN;
      pur_pkg::B_SCAN: begin
        state_next = (lo_ok && hi_ok) || scan_end ? pur_pkg::B_A_RD : pur_pkg::B_SCAN_RD;
      end
      pur_pkg::B_A_RD:    state_next = pur_pkg::B_A;
      pur_pkg::B_A:       state_next = single ? pur_pkg::B_FIX : pur_pkg::B_B;
      pur_pkg::B_B:       state_next = pur_pkg::B_PREP;
      pur_pkg::B_PREP:    state_next = trivial ? pur_pkg::B_FIX : pur_pkg::B_MUL;
      pur_pkg::B_MUL:     if (cnt == 7'd32) state_next = pur_pkg::B_IDIV;
      pur_pkg::B_IDIV:    if (cnt == 7'(PW - 1)) state_next = pur_pkg::B_FIX;
      pur_pkg::B_FIX: begin
        // the last axis of a sample waits here for the output register
        if (coord != 2'd2) begin
          state_next = pur_pkg::B_PREP;
        end else if (emit_go) begin
          state_next = (idx + 7'd1 == m_eff) ? pur_pkg::B_IDLE : pur_pkg::B_POS_MUL;
        end
      end
      default: state_next = pur_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    queue_pop = (state == pur_pkg::B_IDLE) && !queue_empty;
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_addr] <= mem_wr.rec;
    end
    rd_q <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pur_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pur_pkg::B_FIX && coord == 2'd2 && emit_go) begin
        out_valid <= 1'b1;
      end else if (sample.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pur_pkg::B_IDLE: begin
        m_eff <= m_clamp;
        idx   <= '0;
        ptr   <= len_m1[AW-1:0];
      end
      pur_pkg::B_TOT: begin
        total <= rd_q.len;
      end
      pur_pkg::B_POS_MUL: begin
        div_num <= PW'({32'd0, idx} * {7'd0, total});
        div_den <= {25'd0, m_eff - 7'd1};
        div_rem <= '0;
        cnt     <= '0;
        coord   <= '0;
        ptr     <= '0;
      end
      pur_pkg::B_POS_DIV: begin
        div_num <= num_new;
        div_rem <= rem_new;
        cnt     <= cnt + 1'b1;
        pos     <= num_new[31:0];
        ptr     <= '0;
      end
      pur_pkg::B_LO: begin
        lo_len <= rd_q.len;
        ptr    <= AW'(1);
      end
      pur_pkg::B_SCAN: begin
        if ((lo_ok && hi_ok) || scan_end) begin
          hi_len <= rd_q.len;
          ptr    <= ptr - 1'b1;
        end else begin
          lo_len <= rd_q.len;
          ptr    <= ptr + 1'b1;
        end
      end
      pur_pkg::B_A_RD: begin
        ptr <= ptr + 1'b1;
      end
      pur_pkg::B_A: begin
        a_rec <= rd_q;
      end
      pur_pkg::B_B: begin
        b_rec <= rd_q;
      end
      pur_pkg::B_PREP: begin
        mul_acc <= '0;
        mul_a   <= PW'(diff_mag);
        mul_b   <= d_mag;
        neg     <= diff[32] ^ d_val[32];
        cnt     <= '0;
        // degenerate case: keep the segment start
        div_num <= '0;
      end
      pur_pkg::B_MUL: begin
        mul_acc <= acc_next;
        mul_a   <= mul_a << 1;
        mul_b   <= mul_b >> 1;
        cnt     <= (cnt == 7'd32) ? '0 : cnt + 1'b1;
        div_num <= acc_next + PW'(seg >> 1);
        div_den <= seg;
        div_rem <= '0;
      end
      pur_pkg::B_IDIV: begin
        div_num <= num_new;
        div_rem <= rem_new;
        cnt     <= cnt + 1'b1;
      end
      pur_pkg::B_FIX: begin
        if (coord != 2'd2) begin
          res[coord] <= r_clamp;
          coord      <= coord + 1'b1;
        end else if (emit_go) begin
          out_x    <= res[0];
          out_y    <= res[1];
          out_z    <= r_clamp;
          out_last <= (idx + 7'd1 == m_eff);
          idx      <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/polyline_uniform_resampler.sv
// A vertex that opens a path is stored at once; others are squared axis by axis, then
// pass a 32-step square root unless the length saturates; vertices past MAX_POINTS drop.
// Emission: per sample, a 66-step divider gives the arc position and the segments are
// scanned, then each axis takes a 33-step multiplier and a 66-step divide; a one-vertex
// path repeats its vertex and skips all of these; one point per word.
// Reset clears control state and sets samples to 16; the vertex store is not cleared.
module polyline_uniform_resampler #(
  parameter int MAX_POINTS = pur_pkg::MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pur_vertex_if.sink   vertex,
  pur_sample_if.source sample,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [6:0]       samples;
  logic             back_busy;
  logic             queue_full, queue_empty, queue_push, queue_pop;
  pur_pkg::job_t    push_job, head_job;
  pur_pkg::mem_wr_t mem_wr;
  logic [AW-1:0]    mem_addr;
  logic [CW-1:0]    path_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples <= pur_pkg::SAMPLES_RESET;
    end else if (cfg_we) begin
      samples <= cfg_wdata;
    end
  end

  pur_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .vertex      (vertex),
    .samples     (samples),
    .back_busy   (back_busy),
    .queue_full  (queue_full),
    .queue_empty (queue_empty),
    .queue_push  (queue_push),
    .queue_job   (push_job),
    .mem_wr      (mem_wr),
    .mem_addr    (mem_addr),
    .path_len    (path_len)
  );

  pur_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (queue_push),
    .push_job (push_job),
    .pop      (queue_pop),
    .head     (head_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  pur_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .mem_wr      (mem_wr),
    .mem_addr    (mem_addr),
    .path_len    (path_len),
    .queue_empty (queue_empty),
    .queue_head  (head_job),
    .queue_pop   (queue_pop),
    .busy        (back_busy),
    .sample      (sample)
  );

endmodule
